@@ src/irs_pkg.sv @@
// ----------------------------------------------------------------------------
// irs_pkg
// Shared constants and helpers for the icon reference scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package irs_pkg;

   localparam int unsigned MAX_PENDING_DEFAULT = 48;

   localparam logic [7:0] CH_LPAREN = 8'h28;  // '('
   localparam logic [7:0] CH_RPAREN = 8'h29;  // ')'
   localparam logic [7:0] CH_N      = 8'h6E;  // 'n'
   localparam logic [7:0] CH_F      = 8'h66;  // 'f'
   localparam logic [7:0] CH_DASH   = 8'h2D;  // '-'
   localparam logic [7:0] CH_USCORE = 8'h5F;  // '_'
   localparam logic [7:0] CH_LOW_A  = 8'h61;  // 'a'
   localparam logic [7:0] CH_LOW_Z  = 8'h7A;  // 'z'
   localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
   localparam logic [7:0] CH_NINE   = 8'h39;  // '9'

   function automatic logic is_name_char(input logic [7:0] c);
      is_name_char = (c >= CH_LOW_A && c <= CH_LOW_Z) ||
                     (c >= CH_ZERO && c <= CH_NINE) ||
                     (c == CH_DASH) || (c == CH_USCORE);
   endfunction

endpackage

`default_nettype wire

@@ src/irs_ram.sv @@
// ----------------------------------------------------------------------------
// irs_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module irs_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 48
) (
   input  wire                       clock,
   input  wire                       wr_en,
   input  wire  [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire  [WIDTH-1:0]          wr_data,
   input  wire                       rd_en,
   input  wire  [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ src/icon_reference_scanner.sv @@
// ----------------------------------------------------------------------------
// icon_reference_scanner
// Finds "(nf-name)" icon references in a byte stream; candidates are held in
// a pending RAM and released as icon or plain text bytes.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  req_    | in  | req_valid/req_stall  | req_byte, req_run_end
//  rsp_    | out | rsp_valid/rsp_stall  | rsp_byte, rsp_kind, rsp_icon_last,
//          |     |                      | rsp_run_done, rsp_burst_last
//
//  Plain text and held bytes are accepted as they come. A release emits
//  the held bytes (one RAM read per beat, read issued ahead of the beat),
//  all but the '(' for an icon, followed by a trailing text byte if any.
//  Input stalls during a release and while a stalled beat sits in the
//  output register.
//  Reset (synchronous) empties the candidate; the RAM needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module icon_reference_scanner #(
   parameter int unsigned MAX_PENDING = irs_pkg::MAX_PENDING_DEFAULT
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   input  wire  [7:0] req_byte,
   input  wire        req_run_end,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic [7:0] rsp_byte,
   output logic       rsp_kind,
   output logic       rsp_icon_last,
   output logic       rsp_run_done,
   output logic       rsp_burst_last
);

   localparam int unsigned AW = $clog2(MAX_PENDING);
   localparam int unsigned CW = $clog2(MAX_PENDING + 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_DRAIN = 2'd1;
   localparam logic [1:0] ST_TAIL  = 2'd2;

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_OPEN = 3'd1;
   localparam logic [2:0] PH_N    = 3'd2;
   localparam logic [2:0] PH_NF   = 3'd3;
   localparam logic [2:0] PH_NAME = 3'd4;

   localparam logic [1:0] TAIL_NONE = 2'd0;
   localparam logic [1:0] TAIL_EMIT = 2'd1;
   localparam logic [1:0] TAIL_HOLD = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [2:0]    phase_ff, phase_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic [CW-1:0] ld_idx_ff, ld_idx_in;
   logic          inflight_ff, inflight_in;
   logic          kind_ff, kind_in;
   logic [1:0]    tail_ff, tail_in;
   logic          end_ff, end_in;
   logic [7:0]    byte_ff, byte_in;

   logic          out_valid_ff, out_valid_in;
   logic [7:0]    out_byte_ff, out_byte_in;
   logic          out_kind_ff, out_kind_in;
   logic          out_icon_last_ff, out_icon_last_in;
   logic          out_run_done_ff, out_run_done_in;
   logic          out_burst_last_ff, out_burst_last_in;

   logic          mem_we;
   logic [AW-1:0] mem_wr_addr;
   logic [7:0]    mem_wr_data;
   logic          mem_re;
   logic [AW-1:0] mem_rd_addr;
   logic [7:0]    mem_rd_data;

   logic          out_free;
   logic          accept;
   logic [7:0]    want;
   logic          ext;
   logic          icon;
   logic          load;
   logic          last;
   logic          more;

   irs_ram #(
      .WIDTH (8),
      .DEPTH (MAX_PENDING)
   ) u_pending (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_re),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      case (phase_ff)
         PH_OPEN: want = irs_pkg::CH_N;
         PH_N:    want = irs_pkg::CH_F;
         default: want = irs_pkg::CH_DASH;
      endcase
   end

   assign ext = ((phase_ff == PH_OPEN || phase_ff == PH_N || phase_ff == PH_NF) &&
                 req_byte == want) ||
                (phase_ff == PH_NAME && irs_pkg::is_name_char(req_byte) &&
                 count_ff < CW'(MAX_PENDING));
   assign icon = (phase_ff == PH_NAME) && (req_byte == irs_pkg::CH_RPAREN);

   assign load = (state_ff == ST_DRAIN) && inflight_ff && out_free;
   assign last = (ld_idx_ff == count_ff - CW'(1));
   assign more = (rd_idx_ff < count_ff);

   always_comb begin
      state_in          = state_ff;
      phase_in          = phase_ff;
      count_in          = count_ff;
      rd_idx_in         = rd_idx_ff;
      ld_idx_in         = ld_idx_ff;
      inflight_in       = inflight_ff;
      kind_in           = kind_ff;
      tail_in           = tail_ff;
      end_in            = end_ff;
      byte_in           = byte_ff;
      out_valid_in      = out_valid_ff && rsp_stall;
      out_byte_in       = out_byte_ff;
      out_kind_in       = out_kind_ff;
      out_icon_last_in  = out_icon_last_ff;
      out_run_done_in   = out_run_done_ff;
      out_burst_last_in = out_burst_last_ff;
      mem_we            = 1'b0;
      mem_wr_addr       = '0;
      mem_wr_data       = req_byte;
      mem_re            = 1'b0;
      mem_rd_addr       = rd_idx_ff[AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (phase_ff == PH_IDLE) begin
                  if (req_byte == irs_pkg::CH_LPAREN && !req_run_end) begin
                     mem_we   = 1'b1;
                     count_in = CW'(1);
                     phase_in = PH_OPEN;
                  end else begin
                     out_valid_in      = 1'b1;
                     out_byte_in       = req_byte;
                     out_kind_in       = 1'b0;
                     out_icon_last_in  = 1'b0;
                     out_run_done_in   = req_run_end;
                     out_burst_last_in = 1'b1;
                     count_in          = '0;
                  end
               end else if (ext && !req_run_end) begin
                  mem_we      = 1'b1;
                  mem_wr_addr = count_ff[AW-1:0];
                  count_in    = count_ff + CW'(1);
                  phase_in    = (phase_ff == PH_NAME) ? PH_NAME : phase_ff + 3'd1;
               end else begin
                  // release the candidate; icon skips the '(' at entry 0
                  mem_re      = 1'b1;
                  mem_rd_addr = AW'(icon);
                  ld_idx_in   = CW'(icon);
                  rd_idx_in   = CW'(icon) + CW'(1);
                  inflight_in = 1'b1;
                  kind_in     = icon;
                  end_in      = req_run_end;
                  byte_in     = req_byte;
                  state_in    = ST_DRAIN;
                  if (icon) begin
                     tail_in = TAIL_NONE;
                  end else if (!ext && !req_run_end &&
                               req_byte == irs_pkg::CH_LPAREN) begin
                     tail_in = TAIL_HOLD;
                  end else begin
                     tail_in = TAIL_EMIT;
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (load) begin
               out_valid_in      = 1'b1;
               out_byte_in       = mem_rd_data;
               out_kind_in       = kind_ff;
               out_icon_last_in  = kind_ff && last;
               out_burst_last_in = last && (tail_ff != TAIL_EMIT);
               out_run_done_in   = last && (tail_ff != TAIL_EMIT) && end_ff;
               inflight_in       = 1'b0;
            end
            if ((!inflight_ff || load) && more) begin
               mem_re      = 1'b1;
               ld_idx_in   = rd_idx_ff;
               rd_idx_in   = rd_idx_ff + CW'(1);
               inflight_in = 1'b1;
            end
            if (load && last) begin
               case (tail_ff)
                  TAIL_HOLD: begin
                     mem_we      = 1'b1;
                     mem_wr_data = byte_ff;
                     count_in    = CW'(1);
                     phase_in    = PH_OPEN;
                     state_in    = ST_IDLE;
                  end
                  TAIL_EMIT: begin
                     count_in = '0;
                     phase_in = PH_IDLE;
                     state_in = ST_TAIL;
                  end
                  default: begin
                     count_in = '0;
                     phase_in = PH_IDLE;
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_TAIL: begin
            if (out_free) begin
               out_valid_in      = 1'b1;
               out_byte_in       = byte_ff;
               out_kind_in       = 1'b0;
               out_icon_last_in  = 1'b0;
               out_run_done_in   = end_ff;
               out_burst_last_in = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         inflight_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         inflight_ff  <= inflight_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff         <= rd_idx_in;
      ld_idx_ff         <= ld_idx_in;
      kind_ff           <= kind_in;
      tail_ff           <= tail_in;
      end_ff            <= end_in;
      byte_ff           <= byte_in;
      out_byte_ff       <= out_byte_in;
      out_kind_ff       <= out_kind_in;
      out_icon_last_ff  <= out_icon_last_in;
      out_run_done_ff   <= out_run_done_in;
      out_burst_last_ff <= out_burst_last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_byte       = out_byte_ff;
   assign rsp_kind       = out_kind_ff;
   assign rsp_icon_last  = out_icon_last_ff;
   assign rsp_run_done   = out_run_done_ff;
   assign rsp_burst_last = out_burst_last_ff;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives text runs into icon_reference_scanner with random gaps and output
// stalls. Each accepted byte is scanned by a local predictor, and every
// output beat is checked field by field against the oldest predicted beat.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_HELD    = irs_pkg::MAX_PENDING_DEFAULT;
   localparam int RANDOM_ITEMS = 180;
   localparam int IDLE_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 60;

   typedef enum logic [2:0] {
      SCAN_IDLE, SCAN_OPEN, SCAN_N, SCAN_NF, SCAN_NAME
   } scan_phase_type;

   typedef struct {
      logic [7:0] data;
      logic       run_end;
   } text_item_type;

   typedef struct {
      logic [7:0] data;
      logic       kind;
      logic       icon_last;
      logic       run_done;
      logic       burst_last;
   } out_beat_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_byte = 8'h00;
   logic       req_run_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_byte;
   logic       rsp_kind;
   logic       rsp_icon_last;
   logic       rsp_run_done;
   logic       rsp_burst_last;

   icon_reference_scanner uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_byte      (req_byte),
      .req_run_end   (req_run_end),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_byte      (rsp_byte),
      .rsp_kind      (rsp_kind),
      .rsp_icon_last (rsp_icon_last),
      .rsp_run_done  (rsp_run_done),
      .rsp_burst_last(rsp_burst_last)
   );

   text_item_type  text_to_send[$];
   out_beat_type   expected_beats[$];
   out_beat_type   burst_beats[$];
   logic [7:0]     cand[$];
   int unsigned    mismatches = 0;

   // predictor state
   logic [7:0]     held [MAX_HELD];
   int             held_cnt = 0;
   scan_phase_type phase = SCAN_IDLE;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------
   function automatic logic name_byte(input logic [7:0] c);
      return (c >= irs_pkg::CH_LOW_A && c <= irs_pkg::CH_LOW_Z) ||
             (c >= irs_pkg::CH_ZERO && c <= irs_pkg::CH_NINE) ||
             c == irs_pkg::CH_DASH || c == irs_pkg::CH_USCORE;
   endfunction

   task automatic put_beat(input logic [7:0] d, input logic k, input logic last);
      out_beat_type o;
      o.data       = d;
      o.kind       = k;
      o.icon_last  = last;
      o.run_done   = 1'b0;
      o.burst_last = 1'b0;
      burst_beats.push_back(o);
   endtask

   task automatic hold_byte(input logic [7:0] d);
      if (held_cnt < MAX_HELD) begin
         held[held_cnt] = d;
         held_cnt++;
      end
   endtask

   task automatic release_held();
      for (int i = 0; i < held_cnt; i++) put_beat(held[i], 1'b0, 1'b0);
      held_cnt = 0;
      phase    = SCAN_IDLE;
   endtask

   task automatic open_or_text(input logic [7:0] d);
      if (d == irs_pkg::CH_LPAREN) begin
         hold_byte(d);
         phase = SCAN_OPEN;
      end else begin
         put_beat(d, 1'b0, 1'b0);
         phase = SCAN_IDLE;
      end
   endtask

   task automatic scan_byte(input logic [7:0] d, input logic run_end);
      logic [7:0]   want_ch;
      out_beat_type tail;
      burst_beats.delete();
      case (phase)
         SCAN_OPEN, SCAN_N, SCAN_NF: begin
            want_ch = (phase == SCAN_OPEN) ? irs_pkg::CH_N :
                      (phase == SCAN_N)    ? irs_pkg::CH_F : irs_pkg::CH_DASH;
            if (d == want_ch) begin
               hold_byte(d);
               phase = scan_phase_type'(phase + 3'd1);
            end else begin
               release_held();
               open_or_text(d);
            end
         end
         SCAN_NAME: begin
            if (d == irs_pkg::CH_RPAREN) begin
               // held[0] is the opening paren, dropped
               for (int i = 1; i < held_cnt; i++)
                  put_beat(held[i], 1'b1, (i + 1 == held_cnt));
               held_cnt = 0;
               phase    = SCAN_IDLE;
            end else if (name_byte(d)) begin
               if (held_cnt < MAX_HELD) begin
                  hold_byte(d);
               end else begin
                  release_held();
                  put_beat(d, 1'b0, 1'b0);
               end
            end else begin
               release_held();
               open_or_text(d);
            end
         end
         default: begin
            held_cnt = 0;
            open_or_text(d);
         end
      endcase
      if (run_end) release_held();
      if (burst_beats.size() != 0) begin
         tail            = burst_beats.pop_back();
         tail.run_done   = run_end;
         tail.burst_last = 1'b1;
         burst_beats.push_back(tail);
      end
      foreach (burst_beats[i]) expected_beats.push_back(burst_beats[i]);
   endtask

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   function automatic logic [7:0] rand_name_char();
      int unsigned r;
      r = $urandom_range(0, 37);
      if (r < 26) return irs_pkg::CH_LOW_A + 8'(r);
      if (r < 36) return irs_pkg::CH_ZERO + 8'(r - 26);
      return (r == 36) ? irs_pkg::CH_DASH : irs_pkg::CH_USCORE;
   endfunction

   task automatic send(input logic [7:0] d, input logic run_end);
      text_item_type t;
      t.data    = d;
      t.run_end = run_end;
      text_to_send.push_back(t);
   endtask

   task automatic send_str(input string s, input logic end_last);
      for (int i = 0; i < s.len(); i++) send(s[i], end_last && (i == s.len() - 1));
   endtask

   task automatic make_candidate(input int name_len);
      cand.delete();
      cand.push_back(irs_pkg::CH_LPAREN);
      cand.push_back(irs_pkg::CH_N);
      cand.push_back(irs_pkg::CH_F);
      cand.push_back(irs_pkg::CH_DASH);
      repeat (name_len) cand.push_back(rand_name_char());
   endtask

   // idle length: mostly none, some short, a few long; calm stretches with none
   function automatic int unsigned next_idle(inout int unsigned calm);
      int unsigned r;
      if (calm != 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // ------------------------------------------------------------------
   // driver
   // ------------------------------------------------------------------
   int unsigned   gap_left = 0;
   int unsigned   req_calm = 0;
   logic          nxt_valid;
   text_item_type nxt_item;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         nxt_valid = req_valid;
         nxt_item.data    = req_byte;
         nxt_item.run_end = req_run_end;
         if (req_valid && !req_stall) begin
            scan_byte(req_byte, req_run_end);
            nxt_valid = 1'b0;
         end
         if (!nxt_valid) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (text_to_send.size() != 0) begin
               nxt_item  = text_to_send.pop_front();
               nxt_valid = 1'b1;
               gap_left  = next_idle(req_calm);
            end
         end
         req_valid   <= nxt_valid;
         req_byte    <= nxt_item.data;
         req_run_end <= nxt_item.run_end;
      end
   end

   // ------------------------------------------------------------------
   // monitor
   // ------------------------------------------------------------------
   int unsigned  stall_left = 0;
   int unsigned  rsp_calm = 0;
   out_beat_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_beats.size() == 0) begin
               $error("unexpected beat: rsp_byte=%h", rsp_byte);
               mismatches++;
            end else begin
               want = expected_beats.pop_front();
               if (rsp_byte !== want.data) begin
                  $error("rsp_byte: expected %h, got %h", want.data, rsp_byte);
                  mismatches++;
               end
               if (rsp_kind !== want.kind) begin
                  $error("rsp_kind: expected %b, got %b", want.kind, rsp_kind);
                  mismatches++;
               end
               if (rsp_icon_last !== want.icon_last) begin
                  $error("rsp_icon_last: expected %b, got %b", want.icon_last, rsp_icon_last);
                  mismatches++;
               end
               if (rsp_run_done !== want.run_done) begin
                  $error("rsp_run_done: expected %b, got %b", want.run_done, rsp_run_done);
                  mismatches++;
               end
               if (rsp_burst_last !== want.burst_last) begin
                  $error("rsp_burst_last: expected %b, got %b",
                         want.burst_last, rsp_burst_last);
                  mismatches++;
               end
            end
         end
         if (stall_left != 0) stall_left--;
         else stall_left = next_idle(rsp_calm);
         rsp_stall <= (stall_left != 0);
      end
   end

   // ------------------------------------------------------------------
   // watchdog: cycles without any beat on either side
   // ------------------------------------------------------------------
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // stimulus and end of run
   // ------------------------------------------------------------------
   initial begin
      int unsigned pick;
      int          len;
      int          cut;
      int          total;

      // directed: byte extremes, empty name, all name classes, broken
      // candidates, flush at run end, then a name that overflows the buffer
      send(8'h00, 1'b0);
      send(8'hFF, 1'b1);
      send_str("(nf-)", 1'b0);
      send_str("(nf-a_0-z9)", 1'b1);
      send_str("(nx", 1'b0);
      send_str("(n(nf-b)", 1'b0);
      send_str("(nf", 1'b1);
      send_str("(nf-", 1'b0);
      repeat (MAX_HELD - 4) send(rand_name_char(), 1'b0);
      send(irs_pkg::CH_USCORE, 1'b0);
      send(irs_pkg::CH_RPAREN, 1'b1);

      total = text_to_send.size() + RANDOM_ITEMS;
      while (text_to_send.size() < total) begin
         pick = $urandom_range(0, 99);
         len  = ($urandom_range(0, 19) == 0) ? $urandom_range(MAX_HELD - 8, MAX_HELD - 2)
                                             : $urandom_range(0, 6);
         make_candidate(len);
         if (pick < 45) begin
            foreach (cand[i]) send(cand[i], $urandom_range(0, 40) == 0);
            send(irs_pkg::CH_RPAREN, $urandom_range(0, 3) == 0);
         end else if (pick < 65) begin
            cut = $urandom_range(1, cand.size());
            for (int i = 0; i < cut; i++) send(cand[i], 1'b0);
            send(($urandom_range(0, 2) == 0) ? irs_pkg::CH_LPAREN
                                             : 8'($urandom_range(0, 255)),
                 $urandom_range(0, 5) == 0);
         end else if (pick < 90) begin
            repeat ($urandom_range(1, 5))
               send(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
         end else begin
            cut = $urandom_range(1, cand.size());
            for (int i = 0; i < cut; i++) send(cand[i], i == cut - 1);
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // negedge sampling keeps these checks clear of the clocked blocks
      do @(negedge clock); while (text_to_send.size() != 0 || req_valid);
      while (expected_beats.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && expected_beats.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
